FILE: src/wpp_pkg.sv
// wpp_pkg: shared types and constants of the wav pcm16 stream parser
// result record, kind and error codes, magic and chunk id constants
// no dependencies
`default_nettype none

package wpp_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [1:0] KindFormat = 2'd0;
  localparam logic [1:0] KindSample = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  localparam logic [2:0] ErrBadMagic   = 3'd0;
  localparam logic [2:0] ErrFmtSmall   = 3'd1;
  localparam logic [2:0] ErrNoFmt      = 3'd2;
  localparam logic [2:0] ErrNotPcm     = 3'd3;
  localparam logic [2:0] ErrNot16Bit   = 3'd4;
  localparam logic [2:0] ErrTruncated  = 3'd5;

  localparam logic [7:0] MagicRiff [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] MagicWave [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

  localparam logic [31:0] IdFmt  = 32'h666D7420;
  localparam logic [31:0] IdData = 32'h64617461;

  localparam logic [31:0] FmtMinLength = 32'd16;
  localparam logic [15:0] FormatPcm    = 16'd1;
  localparam logic [15:0] BitsPcm16    = 16'd16;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_value;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [30:0]        sample_total;
    logic [2:0]         error_code;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

FILE: src/wpp_front.sv
// wpp_front: byte parser of the riff/wave stream, one byte per transfer
// walks header and chunks and pushes at most one result per byte
// depends on wpp_pkg
`default_nettype none

module wpp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        in_byte,
  input  wire logic              stream_end,
  output logic                   push,
  output wpp_pkg::result_t       res
);

  typedef enum logic [2:0] {
    PhHeader,
    PhChunk,
    PhFmt,
    PhSkip,
    PhData,
    PhDone,
    PhError
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] byte_counter, byte_counter_next;
  logic [31:0] chunk_id_shift, chunk_id_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic        magic_ok, magic_ok_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] sample_bits, sample_bits_next;
  logic        format_seen, format_seen_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;

  logic [31:0] count_inc;
  logic [31:0] length_now;
  logic        magic_now;
  logic [30:0] total_now;

  assign count_inc  = byte_counter + 32'd1;
  assign length_now = {in_byte, chunk_length[31:8]};
  assign total_now  = length_now[31:1];

  always_comb begin
    magic_now = magic_ok;
    if (byte_counter < 32'd4 && in_byte != wpp_pkg::MagicRiff[byte_counter[1:0]]) begin
      magic_now = 1'b0;
    end
    if (byte_counter >= 32'd8 && in_byte != wpp_pkg::MagicWave[byte_counter[1:0]]) begin
      magic_now = 1'b0;
    end
  end

  always_comb begin
    phase_next          = phase;
    byte_counter_next   = byte_counter;
    chunk_id_shift_next = chunk_id_shift;
    chunk_length_next   = chunk_length;
    magic_ok_next       = magic_ok;
    format_tag_next     = format_tag;
    channels_seen_next  = channels_seen;
    rate_seen_next      = rate_seen;
    sample_bits_next    = sample_bits;
    format_seen_next    = format_seen;
    low_byte_hold_next  = low_byte_hold;
    push                = 1'b0;
    res                 = '0;

    if (take && phase != PhDone && phase != PhError) begin
      if (stream_end) begin
        push           = 1'b1;
        res.kind       = wpp_pkg::KindError;
        res.error_code = wpp_pkg::ErrTruncated;
        res.last       = 1'b1;
        phase_next     = PhError;
      end else begin
        unique case (phase)
          PhHeader: begin
            chunk_id_shift_next = {chunk_id_shift[23:0], in_byte};
            magic_ok_next       = magic_now;
            byte_counter_next   = count_inc;
            if (byte_counter >= 32'd11) begin
              if (!magic_now) begin
                push           = 1'b1;
                res.kind       = wpp_pkg::KindError;
                res.error_code = wpp_pkg::ErrBadMagic;
                res.last       = 1'b1;
                phase_next     = PhError;
              end else begin
                phase_next        = PhChunk;
                byte_counter_next = '0;
              end
            end
          end
          PhChunk: begin
            if (byte_counter < 32'd4) begin
              chunk_id_shift_next = {chunk_id_shift[23:0], in_byte};
            end else begin
              chunk_length_next = length_now;
            end
            byte_counter_next = count_inc;
            if (byte_counter >= 32'd7) begin
              byte_counter_next = '0;
              if (chunk_id_shift == wpp_pkg::IdFmt) begin
                if (length_now < wpp_pkg::FmtMinLength) begin
                  push           = 1'b1;
                  res.kind       = wpp_pkg::KindError;
                  res.error_code = wpp_pkg::ErrFmtSmall;
                  res.last       = 1'b1;
                  phase_next     = PhError;
                end else begin
                  phase_next = PhFmt;
                end
              end else if (chunk_id_shift == wpp_pkg::IdData) begin
                push     = 1'b1;
                res.last = 1'b1;
                if (!format_seen) begin
                  res.kind       = wpp_pkg::KindError;
                  res.error_code = wpp_pkg::ErrNoFmt;
                  phase_next     = PhError;
                end else if (format_tag != wpp_pkg::FormatPcm) begin
                  res.kind       = wpp_pkg::KindError;
                  res.error_code = wpp_pkg::ErrNotPcm;
                  phase_next     = PhError;
                end else if (sample_bits != wpp_pkg::BitsPcm16) begin
                  res.kind       = wpp_pkg::KindError;
                  res.error_code = wpp_pkg::ErrNot16Bit;
                  phase_next     = PhError;
                end else begin
                  res.kind          = wpp_pkg::KindFormat;
                  res.sample_rate   = rate_seen;
                  res.channel_count = channels_seen;
                  res.sample_total  = total_now;
                  res.last          = (total_now == '0);
                  phase_next        = (total_now == '0) ? PhDone : PhData;
                end
              end else if (length_now != '0) begin
                phase_next        = PhSkip;
                byte_counter_next = length_now;
              end
            end
          end
          PhFmt: begin
            if (byte_counter < 32'd2) begin
              format_tag_next = {in_byte, format_tag[15:8]};
            end else if (byte_counter < 32'd4) begin
              channels_seen_next = {in_byte, channels_seen[15:8]};
            end else if (byte_counter < 32'd8) begin
              rate_seen_next = {in_byte, rate_seen[31:8]};
            end else if (byte_counter >= 32'd14) begin
              sample_bits_next = {in_byte, sample_bits[15:8]};
            end
            byte_counter_next = count_inc;
            if (byte_counter >= 32'd15) begin
              format_seen_next  = 1'b1;
              byte_counter_next = chunk_length - wpp_pkg::FmtMinLength;
              phase_next = (chunk_length != wpp_pkg::FmtMinLength) ? PhSkip : PhChunk;
            end
          end
          PhSkip: begin
            byte_counter_next = byte_counter - 32'd1;
            if (byte_counter == 32'd1) begin
              phase_next = PhChunk;
            end
          end
          PhData: begin
            byte_counter_next = count_inc;
            if (!byte_counter[0]) begin
              low_byte_hold_next = in_byte;
            end else begin
              push             = 1'b1;
              res.kind         = wpp_pkg::KindSample;
              res.sample_value = {in_byte, low_byte_hold};
              res.last         = (count_inc == {chunk_length[31:1], 1'b0});
              if (res.last) begin
                phase_next = PhDone;
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PhHeader;
      byte_counter   <= '0;
      chunk_id_shift <= '0;
      chunk_length   <= '0;
      magic_ok       <= 1'b1;
      format_tag     <= '0;
      channels_seen  <= '0;
      rate_seen      <= '0;
      sample_bits    <= '0;
      format_seen    <= 1'b0;
      low_byte_hold  <= '0;
    end else begin
      phase          <= phase_next;
      byte_counter   <= byte_counter_next;
      chunk_id_shift <= chunk_id_shift_next;
      chunk_length   <= chunk_length_next;
      magic_ok       <= magic_ok_next;
      format_tag     <= format_tag_next;
      channels_seen  <= channels_seen_next;
      rate_seen      <= rate_seen_next;
      sample_bits    <= sample_bits_next;
      format_seen    <= format_seen_next;
      low_byte_hold  <= low_byte_hold_next;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PhError |=> phase == PhError)
    else $error("error phase left");

  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    push |-> take)
    else $error("result without an accepted byte");

  a_last_ends_parse: assert property (@(posedge clk) disable iff (rst)
    push && res.last |=> (phase == PhDone || phase == PhError))
    else $error("parser still running after final result");

  a_quiet_when_finished: assert property (@(posedge clk) disable iff (rst)
    (phase == PhDone || phase == PhError) |-> !push)
    else $error("result after end of file");

endmodule

`default_nettype wire

FILE: src/wpp_queue.sv
// wpp_queue: short result queue between the parser and the output channel
// holds result records, head drives the output transfer
// depends on wpp_pkg
`default_nettype none

module wpp_queue #(
  parameter int unsigned Depth = wpp_pkg::QueueDepthDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wpp_pkg::result_t       push_data,
  output logic                   full,
  output logic                   head_valid,
  input  wire logic              pop,
  output wpp_pkg::result_t       head
);

  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]   PtrLast = PtrW'(Depth - 1);
  localparam logic [CountW-1:0] CountFull = CountW'(Depth);

  wpp_pkg::result_t entries [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CountW-1:0] count;
  logic              do_pop;

  assign full       = (count == CountFull);
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CountW'(1);
      end else if (!push && do_pop) begin
        count <= count - CountW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountFull)
    else $error("queue count out of range");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    push && do_pop |=> count == $past(count))
    else $error("count moved on push with pop");

endmodule

`default_nettype wire

FILE: src/wav_pcm16_stream_parser_top.sv
// wav_pcm16_stream_parser_top: riff/wave 16-bit pcm stream parser
// Takes one byte of a WAV file per input transfer, at a rate of one byte per
// clock cycle while in_stall is low. Each byte gives at most one result
// (format record at the start of the data chunk, one sample per two data
// bytes, or a sticky error), which is written into the queue as its byte
// is taken. The parser and the output are parted by a queue of QueueDepth
// results; in_stall rises only while that queue is full, so bytes keep
// flowing at one a cycle as long as the output side takes one result a cycle.
// After the final result (last sample, empty data chunk or error) further bytes
// are taken and give nothing until reset. There is no clearing pass after reset.
// depends on wpp_pkg, wpp_front, wpp_queue
`default_nettype none

module wav_pcm16_stream_parser_top #(
  parameter int unsigned QueueDepth = wpp_pkg::QueueDepthDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte,
  input  wire logic               stream_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic signed [15:0]      sample_value,
  output logic [31:0]             sample_rate,
  output logic [15:0]             channel_count,
  output logic [30:0]             sample_total,
  output logic [2:0]              error_code,
  output logic                    last
);

  logic             take;
  logic             push;
  logic             full;
  wpp_pkg::result_t res;
  wpp_pkg::result_t head;

  assign in_stall = full;
  assign take     = in_valid && !full;

  wpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (in_byte),
    .stream_end (stream_end),
    .push       (push),
    .res        (res)
  );

  wpp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .full       (full),
    .head_valid (out_valid),
    .pop        (!out_stall),
    .head       (head)
  );

  assign kind          = head.kind;
  assign sample_value  = head.sample_value;
  assign sample_rate   = head.sample_rate;
  assign channel_count = head.channel_count;
  assign sample_total  = head.sample_total;
  assign error_code    = head.error_code;
  assign last          = head.last;

endmodule

`default_nettype wire

FILE: bench/wav_pcm16_stream_parser_top_tb.sv
// testbench for wav_pcm16_stream_parser_top: feeds one wav file byte by byte and
// checks every result against a cycle-free model of the riff/wave parser
// depends on wpp_pkg and the parser rtl
module wav_pcm16_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] IdList = 32'h4C495354;

  typedef enum logic [2:0] {
    PrsHeader, PrsChunk, PrsFmt, PrsSkip, PrsData, PrsDone, PrsError
  } parse_phase_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_byte;
  logic               stream_end;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         kind;
  logic signed [15:0] sample_value;
  logic [31:0]        sample_rate;
  logic [15:0]        channel_count;
  logic [30:0]        sample_total;
  logic [2:0]         error_code;
  logic               last;

  wav_pcm16_stream_parser_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .stream_end(stream_end),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .sample_value(sample_value), .sample_rate(sample_rate),
    .channel_count(channel_count), .sample_total(sample_total),
    .error_code(error_code), .last(last)
  );

  // parser model state
  parse_phase_t prs_phase = PrsHeader;
  logic [31:0]  prs_count = '0;
  logic [31:0]  prs_id = '0;
  logic [31:0]  prs_len = '0;
  logic         prs_magic_good = 1'b1;
  logic [15:0]  prs_tag = '0;
  logic [15:0]  prs_chans = '0;
  logic [31:0]  prs_rate = '0;
  logic [15:0]  prs_bits = '0;
  logic         prs_have_fmt = 1'b0;
  logic [7:0]   prs_low = '0;

  wpp_pkg::result_t pending_results[$];
  int unsigned mismatches = 0;
  logic        tx_idle = 1'b1;
  logic        rx_idle = 1'b1;
  int unsigned rx_long_hold = 0;
  int unsigned rx_wait = 0;

  function automatic wpp_pkg::result_t error_result(input logic [2:0] code);
    wpp_pkg::result_t r;
    r = '0;
    r.kind = wpp_pkg::KindError;
    r.error_code = code;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    wpp_pkg::result_t r;
    logic        emit;
    logic [31:0] pos;
    r = '0;
    emit = 1'b0;
    pos = prs_count;
    if (prs_phase == PrsDone || prs_phase == PrsError) return;
    if (eos) begin
      r = error_result(wpp_pkg::ErrTruncated);
      emit = 1'b1;
    end else begin
      case (prs_phase)
        PrsHeader: begin
          prs_id = {prs_id[23:0], b};
          if (pos < 4 && b != wpp_pkg::MagicRiff[pos[1:0]]) prs_magic_good = 1'b0;
          if (pos >= 8 && b != wpp_pkg::MagicWave[pos[1:0]]) prs_magic_good = 1'b0;
          prs_count = pos + 1;
          if (pos >= 11) begin
            if (!prs_magic_good) begin
              r = error_result(wpp_pkg::ErrBadMagic);
              emit = 1'b1;
            end else begin
              prs_phase = PrsChunk;
              prs_count = '0;
            end
          end
        end
        PrsChunk: begin
          if (pos < 4) prs_id = {prs_id[23:0], b};
          else prs_len = {b, prs_len[31:8]};
          prs_count = pos + 1;
          if (pos >= 7) begin
            prs_count = '0;
            if (prs_id == wpp_pkg::IdFmt) begin
              if (prs_len < wpp_pkg::FmtMinLength) begin
                r = error_result(wpp_pkg::ErrFmtSmall);
                emit = 1'b1;
              end else begin
                prs_phase = PrsFmt;
              end
            end else if (prs_id == wpp_pkg::IdData) begin
              emit = 1'b1;
              if (!prs_have_fmt) r = error_result(wpp_pkg::ErrNoFmt);
              else if (prs_tag != wpp_pkg::FormatPcm) r = error_result(wpp_pkg::ErrNotPcm);
              else if (prs_bits != wpp_pkg::BitsPcm16) begin
                r = error_result(wpp_pkg::ErrNot16Bit);
              end else begin
                r.kind = wpp_pkg::KindFormat;
                r.sample_rate = prs_rate;
                r.channel_count = prs_chans;
                r.sample_total = prs_len[31:1];
                r.last = (prs_len[31:1] == '0);
                prs_phase = r.last ? PrsDone : PrsData;
              end
            end else if (prs_len != '0) begin
              prs_phase = PrsSkip;
              prs_count = prs_len;
            end
          end
        end
        PrsFmt: begin
          if (pos < 2) prs_tag = {b, prs_tag[15:8]};
          else if (pos < 4) prs_chans = {b, prs_chans[15:8]};
          else if (pos < 8) prs_rate = {b, prs_rate[31:8]};
          else if (pos >= 14) prs_bits = {b, prs_bits[15:8]};
          prs_count = pos + 1;
          if (pos >= 15) begin
            prs_have_fmt = 1'b1;
            prs_count = prs_len - 32'd16;
            prs_phase = (prs_count != '0) ? PrsSkip : PrsChunk;
          end
        end
        PrsSkip: begin
          prs_count = pos - 1;
          if (prs_count == '0) prs_phase = PrsChunk;
        end
        PrsData: begin
          prs_count = pos + 1;
          if (!pos[0]) begin
            prs_low = b;
          end else begin
            r.kind = wpp_pkg::KindSample;
            r.sample_value = {b, prs_low};
            r.last = (prs_count == {prs_len[31:1], 1'b0});
            emit = 1'b1;
            if (r.last) prs_phase = PrsDone;
          end
        end
        default: ;
      endcase
    end
    if (emit) begin
      if (r.kind == wpp_pkg::KindError) prs_phase = PrsError;
      pending_results.push_back(r);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stall after each transfer, plus long hold-offs on request
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_long_hold > 0) begin
        out_stall <= 1'b1;
        rx_long_hold--;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else if (out_valid && !out_stall) begin
        n = rx_idle ? $urandom_range(0, 4) : 0;
        out_stall <= (n > 0);
        rx_wait = (n > 0) ? n - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    wpp_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d", kind);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("sample_value", 32'(want.sample_value), 32'(sample_value));
        check_field("sample_rate", want.sample_rate, sample_rate);
        check_field("channel_count", 32'(want.channel_count), 32'(channel_count));
        check_field("sample_total", 32'(want.sample_total), 32'(sample_total));
        check_field("error_code", 32'(want.error_code), 32'(error_code));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    stream_end <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, eos);
  endtask

  task automatic send_id(input logic [31:0] id);
    for (int i = 3; i >= 0; i--) send_byte(id[8*i +: 8], 1'b0);
  endtask

  task automatic send_le(input logic [31:0] v, input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) send_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_random_bytes(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_chunk_header(input logic [31:0] id, input logic [31:0] len);
    send_id(id);
    send_le(len, 4);
  endtask

  task automatic send_fmt_chunk(input logic [15:0] tag, input logic [15:0] chans,
                                input logic [31:0] rate, input logic [15:0] bits,
                                input logic [31:0] len);
    send_chunk_header(wpp_pkg::IdFmt, len);
    send_le(32'(tag), 2);
    send_le(32'(chans), 2);
    send_le(rate, 4);
    send_random_bytes(6);
    send_le(32'(bits), 2);
    send_random_bytes(len - 16);
  endtask

  task automatic send_other_chunk(input logic [31:0] len);
    logic [31:0] id;
    do id = $urandom; while (id == wpp_pkg::IdFmt || id == wpp_pkg::IdData);
    send_chunk_header(id, len);
    send_random_bytes(len);
  endtask

  task automatic test_riff_header();
    for (int i = 0; i < 4; i++) send_byte(wpp_pkg::MagicRiff[i], 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_random_bytes(2);
    for (int i = 0; i < 4; i++) send_byte(wpp_pkg::MagicWave[i], 1'b0);
  endtask

  task automatic test_skipped_chunks();
    // zero length chunk, then an odd length one with no pad byte
    send_chunk_header(IdList, 32'd0);
    send_other_chunk(32'd3);
  endtask

  task automatic test_fmt_overwrite();
    send_fmt_chunk(16'd3, 16'd2, 32'd48000, 16'd32, 32'd18);
    send_fmt_chunk(wpp_pkg::FormatPcm, 16'hffff, 32'hffff_ffff, wpp_pkg::BitsPcm16, 32'd16);
  endtask

  task automatic test_random_chunks();
    int unsigned n;
    n = $urandom_range(4, 7);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_fmt_chunk(16'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)), $urandom,
                       ($urandom_range(0, 1) == 0) ? wpp_pkg::BitsPcm16 : 16'($urandom),
                       $urandom_range(16, 22));
      else
        send_other_chunk($urandom_range(0, 12));
    end
    send_fmt_chunk(wpp_pkg::FormatPcm, 16'($urandom_range(0, 65535)), $urandom,
                   wpp_pkg::BitsPcm16, $urandom_range(16, 20));
  endtask

  task automatic test_sample_stream();
    int unsigned len;
    int unsigned cut_at;
    logic        cut;
    len = $urandom_range(380, 440);
    cut = ($urandom_range(0, 3) == 0);
    cut_at = $urandom_range(340, len - 1);
    send_chunk_header(wpp_pkg::IdData, len);
    // most negative, most positive, zero, minus one
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    for (int unsigned k = 8; k < len; k++) begin
      if (cut && k == cut_at) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        break;
      end
      if (k == 100) rx_long_hold = 60;
      if (k == 200) begin
        // sender pause until the output side has caught up
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      tx_idle = !(k >= 260 && k < 330);
      rx_idle = tx_idle;
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_after_end();
    send_random_bytes(5);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_random_bytes(3);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= '0;
    stream_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_riff_header();
    test_skipped_chunks();
    test_fmt_overwrite();
    test_random_chunks();
    test_sample_stream();
    test_after_end();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: wav_pcm16_stream_parser_top.f
src/wpp_pkg.sv
src/wpp_front.sv
src/wpp_queue.sv
src/wav_pcm16_stream_parser_top.sv
bench/wav_pcm16_stream_parser_top_tb.sv
